>>> rtl/core/ascii85_stream_encoder_top_assert.svh
// assertion macros used by the checker file
`ifndef ASCII85_STREAM_ENCODER_TOP_ASSERT_SVH
`define ASCII85_STREAM_ENCODER_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define A85_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define A85_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/asc85_pkg.sv
`default_nettype none
package asc85_pkg;

  // field widths
  localparam int unsigned LW_W   = 10;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIG_W  = 7;

  // line width after reset
  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 10'd72;

  // register index decoded from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;

  // default depth of the job queue
  localparam int unsigned QUEUE_DEPTH = 4;

  // reciprocal of 85 scaled by 2^38, exact for every 32-bit dividend
  localparam logic [31:0] RECIP_85    = 32'd3233857729;
  localparam int unsigned RECIP_SHIFT = 38;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7e;
  localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3e;

  // one unit of work for the back end
  typedef struct packed {
    logic [31:0] word;  // group, big-endian, zero padded
    logic [2:0]  ndig;  // characters to emit from the group (0..5)
    logic        zero;  // all-zero full group, emit 'z'
    logic        eos;   // terminate the stream after the digits
  } job_t;

endpackage
`default_nettype wire

>>> rtl/core/asc85_queue.sv
`default_nettype none
module asc85_queue #(
  parameter int unsigned DEPTH = asc85_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  asc85_pkg::job_t   push_data_i,
  output logic              full_o,
  input  wire               pop_i,
  output asc85_pkg::job_t   pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  asc85_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/asc85_front.sv
`default_nettype none
module asc85_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  wire              command_i,
  input  wire [7:0]        data_byte_i,
  input  wire              full_i,
  output logic             push_o,
  output asc85_pkg::job_t  job_o
);

  logic [1:0]  byte_count_q;
  logic [31:0] group_q;
  logic [31:0] merged;
  logic [4:0]  shift;
  logic        fire;
  logic        group_done;

  assign ready_o    = !full_i;
  assign fire       = valid_i && ready_o;
  assign group_done = command_i || (byte_count_q == 2'd3);
  assign push_o     = fire && group_done;

  // place the byte big-endian into the group
  assign shift  = {~byte_count_q, 3'b000};
  assign merged = group_q | (32'(data_byte_i) << shift);

  // classify the request into a job
  always_comb begin
    job_o.eos = command_i;
    if (command_i) begin
      job_o.word = group_q;
      job_o.zero = 1'b0;
      job_o.ndig = (byte_count_q == 2'd0) ? 3'd0 : 3'(byte_count_q + 2'd1);
    end else begin
      job_o.word = merged;
      job_o.zero = (merged == 32'd0);
      job_o.ndig = (merged == 32'd0) ? 3'd1 : 3'd5;
    end
  end

  // partial group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 2'd0;
      group_q      <= 32'd0;
    end else if (fire) begin
      if (group_done) begin
        byte_count_q <= 2'd0;
        group_q      <= 32'd0;
      end else begin
        byte_count_q <= 2'(byte_count_q + 2'd1);
        group_q      <= merged;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/asc85_back.sv
`default_nettype none
module asc85_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  asc85_pkg::job_t            job_i,
  input  wire                        empty_i,
  output logic                       pop_o,
  input  wire [asc85_pkg::LW_W-1:0]  line_width_i,
  output logic                       m_valid_o,
  input  wire                        m_ready_i,
  output logic [7:0]                 m_char_o,
  output logic                       m_last_o,
  output logic                       m_end_o
);

  localparam int unsigned LW_W  = asc85_pkg::LW_W;
  localparam int unsigned DIG_W = asc85_pkg::DIG_W;
  localparam int unsigned Q_W   = 64 - asc85_pkg::RECIP_SHIFT;

  // converter states
  localparam logic [1:0] CV_EMPTY = 2'd0;
  localparam logic [1:0] CV_RUN   = 2'd1;
  localparam logic [1:0] CV_DONE  = 2'd2;

  // emitter states
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CNT   = 3'd1;
  localparam logic [2:0] PH_NL    = 3'd2;
  localparam logic [2:0] PH_ENL   = 3'd3;
  localparam logic [2:0] PH_TILDE = 3'd4;
  localparam logic [2:0] PH_GT    = 3'd5;

  // converter registers
  logic [1:0]       cv_st_q, cv_st_d;
  logic [2:0]       cnt_q;
  logic [63:0]      prod_q;
  logic [31:0]      wprev_q;
  logic [DIG_W-1:0] c_dig_q [5];
  logic [2:0]       c_ndig_q;
  logic             c_zero_q, c_eos_q;

  logic [Q_W-1:0]   q_val;
  logic [DIG_W-1:0] rem;
  logic [31:0]      mul_a;
  logic [63:0]      mul_p;

  // emitter registers
  logic [2:0]       ph_q, ph_d;
  logic [2:0]       idx_q, idx_d;
  logic [LW_W-1:0]  column_q, column_d;
  logic [DIG_W-1:0] e_dig_q [5];
  logic [2:0]       e_ndig_q;
  logic             e_zero_q, e_eos_q;

  logic             load, adv, fire;
  logic             more, nl_cnt;
  logic [2:0]       idx_inc;
  logic [LW_W-1:0]  col_inc;
  logic [2:0]       ph_after;
  logic [7:0]       ch;
  logic             ch_last, ch_end;

  // output register
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q, out_end_q;

  // one step of divide by 85: quotient from the product, remainder in 7 bits
  assign q_val = prod_q[63 -: Q_W];
  assign rem   = DIG_W'(wprev_q[DIG_W-1:0] - DIG_W'(q_val[DIG_W-1:0] * 7'd85));
  assign mul_a = (cv_st_q == CV_EMPTY) ? job_i.word : 32'(q_val);
  assign mul_p = mul_a * asc85_pkg::RECIP_85;

  assign pop_o = (cv_st_q == CV_EMPTY) && !empty_i;
  assign load  = (cv_st_q == CV_DONE) && (ph_q == PH_IDLE);

  // converter sequencing
  always_comb begin
    cv_st_d = cv_st_q;
    unique case (cv_st_q)
      CV_EMPTY: if (pop_o) cv_st_d = CV_RUN;
      CV_RUN:   if (cnt_q == 3'd4) cv_st_d = CV_DONE;
      CV_DONE:  if (load) cv_st_d = CV_EMPTY;
      default:  cv_st_d = CV_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_st_q <= CV_EMPTY;
      cnt_q   <= 3'd0;
    end else begin
      cv_st_q <= cv_st_d;
      if (pop_o) begin
        cnt_q <= 3'd0;
      end else if (cv_st_q == CV_RUN) begin
        cnt_q <= 3'(cnt_q + 3'd1);
      end
    end
  end

  // converter datapath, digits land least significant first
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q   <= mul_p;
      wprev_q  <= job_i.word;
      c_ndig_q <= job_i.ndig;
      c_zero_q <= job_i.zero;
      c_eos_q  <= job_i.eos;
    end else if (cv_st_q == CV_RUN) begin
      prod_q                 <= mul_p;
      wprev_q                <= 32'(q_val);
      c_dig_q[3'd4 - cnt_q]  <= rem;
    end
  end

  // emitter decisions
  assign adv     = !out_valid_q || m_ready_i;
  assign fire    = adv && (ph_q != PH_IDLE);
  assign idx_inc = 3'(idx_q + 3'd1);
  assign more    = (idx_inc < e_ndig_q);
  assign nl_cnt  = (column_q >= line_width_i);
  assign col_inc = LW_W'(column_q + 1'b1);

  always_comb begin
    ph_d     = ph_q;
    idx_d    = idx_q;
    column_d = column_q;
    ch       = asc85_pkg::CHAR_NL;
    ch_last  = 1'b0;
    ch_end   = 1'b0;
    ph_after = PH_IDLE;
    unique case (ph_q)
      PH_IDLE: begin
        if (load) begin
          idx_d = 3'd0;
          if (c_eos_q && (c_ndig_q == 3'd0)) begin
            ph_d = (({1'b0, column_q} + 11'd2) > {1'b0, line_width_i}) ? PH_ENL : PH_TILDE;
          end else begin
            ph_d = PH_CNT;
          end
        end
      end
      PH_CNT: begin
        ch = e_zero_q ? asc85_pkg::CHAR_Z
                      : 8'(e_dig_q[idx_q]) + asc85_pkg::CHAR_BANG;
        column_d = nl_cnt ? '0 : col_inc;
        // terminator check sees the column after this character
        if (e_eos_q) begin
          ph_after = (({1'b0, column_d} + 11'd2) > {1'b0, line_width_i}) ? PH_ENL : PH_TILDE;
        end
        ch_last = !nl_cnt && !more && !e_eos_q;
        if (fire) begin
          if (nl_cnt) begin
            ph_d = PH_NL;
          end else if (more) begin
            idx_d = idx_inc;
          end else begin
            ph_d = ph_after;
          end
        end
      end
      PH_NL: begin
        ch = asc85_pkg::CHAR_NL;
        if (e_eos_q) begin
          ph_after = (11'd2 > {1'b0, line_width_i}) ? PH_ENL : PH_TILDE;
        end
        ch_last = !more && !e_eos_q;
        if (fire) begin
          if (more) begin
            idx_d = idx_inc;
            ph_d  = PH_CNT;
          end else begin
            ph_d = ph_after;
          end
        end
      end
      PH_ENL: begin
        ch = asc85_pkg::CHAR_NL;
        if (fire) ph_d = PH_TILDE;
      end
      PH_TILDE: begin
        ch = asc85_pkg::CHAR_TILDE;
        if (fire) ph_d = PH_GT;
      end
      PH_GT: begin
        ch       = asc85_pkg::CHAR_GT;
        ch_last  = 1'b1;
        ch_end   = 1'b1;
        column_d = '0;
        if (fire) ph_d = PH_IDLE;
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  // emitter control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      idx_q    <= 3'd0;
      column_q <= '0;
    end else begin
      ph_q  <= ph_d;
      idx_q <= idx_d;
      if (fire) begin
        column_q <= column_d;
      end
    end
  end

  // job payload handed over from the converter
  always_ff @(posedge clk_i) begin
    if (load) begin
      e_dig_q  <= c_dig_q;
      e_ndig_q <= c_ndig_q;
      e_zero_q <= c_zero_q;
      e_eos_q  <= c_eos_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_char_q <= ch;
      out_last_q <= ch_last;
      out_end_q  <= ch_end;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;
  assign m_end_o   = out_end_q;

endmodule
`default_nettype wire

>>> rtl/core/ascii85_stream_encoder_top.sv
`default_nettype none
// Ascii85 stream encoder. Bytes enter on the slave stream (tuser low) and are
// packed big-endian into 32-bit groups; a request with tuser high ends the
// stream, flushing a partial group as n+1 digits, then an optional newline
// and "~>" (tuser high on the '>'), and clears all state. A full zero group
// becomes 'z'. Newlines are inserted after a character whenever the column
// has reached line_width (APB register at address 0, reset 72). tlast marks
// the final character produced by each request. Input requests are taken in
// every cycle while the job queue (four entries by default) has room. Each
// job then holds the divide-by-85 unit for a load step, five reciprocal
// multiply steps and a handover to the emitter, while the emitter produces
// one output character per cycle after each handover unless the output
// stalls. The two overlap, so the divide unit sets the pace for full groups;
// newlines and output stalls add to that once the emitter is the slower side.
module ascii85_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = asc85_pkg::QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tuser,   // [0] command
  // master stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser,   // [0] stream_end
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LW_W = asc85_pkg::LW_W;

  logic [LW_W-1:0]  line_width_q;
  logic             reg_sel;
  logic             push, full, pop, empty;
  asc85_pkg::job_t  push_job, pop_job;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == asc85_pkg::REG_LINE_WIDTH);
  assign prdata  = reg_sel ? 32'(line_width_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= asc85_pkg::LINE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      line_width_q <= pwdata[LW_W-1:0];
    end
  end

  // front end: byte packing and job classification
  asc85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // job queue
  asc85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // back end: digit conversion and character emission
  asc85_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (pop_job),
    .empty_i      (empty),
    .pop_o        (pop),
    .line_width_i (line_width_q),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_char_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast),
    .m_end_o      (m_axis_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/core/asc85_checker.sv
`default_nettype none
`include "ascii85_stream_encoder_top_assert.svh"
module asc85_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast,
  input wire        m_axis_tuser
);

  // stalled output character holds
  `A85_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")

  // stream end flag only on the closing '>' which ends the request
  `A85_ASSERT(a_end_is_gt, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == asc85_pkg::CHAR_GT), "stream end not on last '>'")

  // '~' is never the last character of a request
  `A85_ASSERT(a_tilde_not_last, m_axis_tvalid && (m_axis_tdata == asc85_pkg::CHAR_TILDE) |-> !m_axis_tlast && !m_axis_tuser, "'~' flagged as last")

  // '>' follows a taken '~' straight away
  `A85_ASSERT_NEXT(a_tilde_then_gt, m_axis_tvalid && m_axis_tready && (m_axis_tdata == asc85_pkg::CHAR_TILDE), m_axis_tvalid && (m_axis_tdata == asc85_pkg::CHAR_GT) && m_axis_tuser, "'~' not followed by '>'")

endmodule

bind ascii85_stream_encoder_top asc85_checker u_asc85_checker (.*);
`default_nettype wire
